/* sv/task_guard_wait_unit_defines.svh */
// Assertion macros for the task guard-wait unit.
// Included by the modules that check their own logic; no other dependencies.
`ifndef TASK_GUARD_WAIT_UNIT_DEFINES_SVH
`define TASK_GUARD_WAIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset-qualified
`define TGW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgw check failed");
// Next-cycle implication, reset-qualified
`define TGW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgw check failed");
`else
`define TGW_ASSERT_NOW(lbl, ante, cons)
`define TGW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/tgw_pkg.sv */
// Shared types and constants of the task guard-wait unit.
// No dependencies.
package tgw_pkg;

    localparam int TASK_IDX_W  = 5;
    localparam int GUARD_IDX_W = 4;
    localparam int TIME_W      = 32;
    localparam int MASK_W      = 32;

    // Operation codes carried by an item
    typedef enum logic [2:0] {
        OP_JOIN_GUARD    = 3'd0,
        OP_NOTE_ACCEPTED = 3'd1,
        OP_WAIT_CHANGE   = 3'd2,
        OP_GUARD_CHANGED = 3'd3,
        OP_ARM_DEADLINE  = 3'd4,
        OP_TICK          = 3'd5
    } op_t;

    // Per-task guard state
    typedef enum logic [1:0] {
        GST_EVALUATING = 2'd0,
        GST_WAITING    = 2'd1,
        GST_CHANGED    = 2'd2
    } guard_state_t;

    // Item travelling down the row of task cells, with its growing result
    typedef struct packed {
        op_t                    op;
        logic [TASK_IDX_W-1:0]  running_task;
        logic [GUARD_IDX_W-1:0] guard_index;
        logic                   accepted;
        logic [TIME_W-1:0]      time_value;
        logic                   user_result;
        logic                   suspend_running;
        logic [MASK_W-1:0]      ready_mask;
    } item_t;

endpackage

/* sv/tgw_req_if.sv */
// Request and response channels of the task guard-wait unit.
// Depends on tgw_pkg for field widths.
interface tgw_req_if
    import tgw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [2:0]             op;
    logic [TASK_IDX_W-1:0]  running_task;
    logic [GUARD_IDX_W-1:0] guard_index;
    logic                   accepted;
    logic [TIME_W-1:0]      time_value;

    modport source (output valid, op, running_task, guard_index, accepted, time_value,
                    input ready);
    modport sink (input valid, op, running_task, guard_index, accepted, time_value,
                  output ready);
endinterface

interface tgw_rsp_if
    import tgw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              user_result;
    logic              suspend_running;
    logic [MASK_W-1:0] ready_mask;

    modport source (output valid, user_result, suspend_running, ready_mask,
                    input ready);
    modport sink (input valid, user_result, suspend_running, ready_mask,
                  output ready);
endinterface

/* sv/tgw_cell.sv */
// One task cell: holds the guard state, membership, deadline of one task and
// applies a passing item to them before handing the item on. Uses tgw_pkg.
module tgw_cell
    import tgw_pkg::*;
#(
    parameter int CELL_INDEX  = 0,
    parameter int GUARD_COUNT = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    input  logic  hold,
    output logic  out_valid,
    output item_t out_item
);

    localparam logic                  IN_RANGE  = (CELL_INDEX < MASK_W);
    localparam logic [TASK_IDX_W-1:0] CELL_TAG  = TASK_IDX_W'(CELL_INDEX);
    localparam logic [MASK_W-1:0]     READY_BIT = IN_RANGE ?
        (MASK_W'(1) << CELL_INDEX) : '0;

    guard_state_t           gs_reg, gs_next;
    logic [GUARD_COUNT-1:0] mem_reg, mem_next;
    logic                   hd_reg, hd_next;
    logic [TIME_W-1:0]      dl_reg, dl_next;
    logic                   valid_reg;
    item_t                  item_reg, item_next;
    logic [GUARD_COUNT-1:0] gsel;
    logic                   take;
    logic                   match;
    logic                   fire;

    assign take  = in_valid && !hold;
    assign match = IN_RANGE && (in_item.running_task == CELL_TAG);

    // one-hot of the named guard, zero when it is out of range
    always_comb
    begin
        for (int j = 0; j < GUARD_COUNT; j++)
        begin
            gsel[j] = ({{(32-GUARD_IDX_W){1'b0}}, in_item.guard_index} == 32'(j));
        end
    end

    // apply the item to this task
    always_comb
    begin
        gs_next   = gs_reg;
        mem_next  = mem_reg;
        hd_next   = hd_reg;
        dl_next   = dl_reg;
        item_next = in_item;
        fire      = 1'b0;
        case (in_item.op)
            OP_JOIN_GUARD:
            begin
                if (match && gs_reg == GST_EVALUATING)
                    mem_next = mem_reg | gsel;
            end
            OP_NOTE_ACCEPTED:
            begin
                if (match && in_item.accepted)
                begin
                    gs_next  = GST_EVALUATING;
                    mem_next = '0;
                    hd_next  = 1'b0;
                end
            end
            OP_WAIT_CHANGE:
            begin
                if (match)
                begin
                    if (gs_reg == GST_CHANGED)
                    begin
                        item_next.user_result = 1'b1;
                        gs_next = GST_EVALUATING;
                    end
                    else if (hd_reg || (mem_reg != '0))
                    begin
                        item_next.user_result     = 1'b1;
                        item_next.suspend_running = 1'b1;
                        gs_next = GST_WAITING;
                    end
                end
            end
            OP_GUARD_CHANGED:
                fire = ((mem_reg & gsel) != '0);
            OP_ARM_DEADLINE:
            begin
                if (match && gs_reg == GST_EVALUATING)
                begin
                    if (!hd_reg || (dl_reg > in_item.time_value))
                        dl_next = in_item.time_value;
                    hd_next = 1'b1;
                end
            end
            OP_TICK:
                fire = hd_reg && (in_item.time_value >= dl_reg);
            default:
                fire = 1'b0;
        endcase

        // guard condition fired: leave guards, then wake or mark
        if (fire)
        begin
            mem_next = '0;
            hd_next  = 1'b0;
            case (gs_reg)
                GST_WAITING:
                begin
                    gs_next = GST_EVALUATING;
                    item_next.ready_mask = in_item.ready_mask | READY_BIT;
                end
                GST_EVALUATING:
                    gs_next = GST_CHANGED;
                default:
                    gs_next = gs_reg;
            endcase
        end
    end

    // task state and hand-off valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg    <= GST_EVALUATING;
            mem_reg   <= '0;
            hd_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                gs_reg  <= gs_next;
                mem_reg <= mem_next;
                hd_reg  <= hd_next;
            end
            if (!hold)
                valid_reg <= in_valid;
        end
    end

    // deadline and hand-off payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dl_reg   <= dl_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* sv/task_guard_wait_unit.sv */
// Top level of the task guard-wait unit: a row of task cells and a result register.
// Uses tgw_pkg, tgw_req_if/tgw_rsp_if, tgw_cell and the assertion macro header.
//
//  channel | dir | fields
//  req     | in  | op, running_task, guard_index, accepted, time_value
//  rsp     | out | user_result, suspend_running, ready_mask
//
// An item enters cell 0 and moves one cell a cycle; each cell updates its own task.
// The result is offered from the result register once the item leaves the last cell; the next
// item is taken only after the result is taken.
// One item in the unit at a time; req.ready is low while it travels or waits in rsp.
// A stall on rsp delays the next item; reset clears guard state, membership and armed flag, not the deadline value.
`include "task_guard_wait_unit_defines.svh"
module task_guard_wait_unit
    import tgw_pkg::*;
#(
    parameter int TASK_COUNT  = 32,
    parameter int GUARD_COUNT = 16
) (
    input  logic clk,
    input  logic rst_n,
    tgw_req_if.sink   req,
    tgw_rsp_if.source rsp
);

    localparam int LAST = TASK_COUNT - 1;

    logic [TASK_COUNT-1:0] stage_valid;
    item_t                 stage_item [TASK_COUNT];
    item_t                 entry_item;
    logic                  entry_valid;
    logic                  out_hold;
    logic                  rsp_valid_reg;
    item_t                 rsp_item_reg;

    // entry: accept only with the row and the result register empty
    assign req.ready   = ~|stage_valid && !rsp_valid_reg;
    assign entry_valid = req.valid && req.ready;

    always_comb
    begin
        entry_item                 = '0;
        entry_item.op              = op_t'(req.op);
        entry_item.running_task    = req.running_task;
        entry_item.guard_index     = req.guard_index;
        entry_item.accepted        = req.accepted;
        entry_item.time_value      = req.time_value;
    end

    assign out_hold = rsp_valid_reg && !rsp.ready;

    // row of task cells
    for (genvar i = 0; i < TASK_COUNT; i++)
    begin : g_cell
        logic  c_in_valid;
        item_t c_in_item;
        logic  c_hold;

        if (i == 0)
        begin : g_head
            assign c_in_valid = entry_valid;
            assign c_in_item  = entry_item;
        end
        else
        begin : g_link
            assign c_in_valid = stage_valid[i-1];
            assign c_in_item  = stage_item[i-1];
        end

        if (i == LAST)
        begin : g_tail
            assign c_hold = out_hold;
        end
        else
        begin : g_mid
            assign c_hold = 1'b0;
        end

        tgw_cell #(
            .CELL_INDEX  (i),
            .GUARD_COUNT (GUARD_COUNT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_in_valid),
            .in_item   (c_in_item),
            .hold      (c_hold),
            .out_valid (stage_valid[i]),
            .out_item  (stage_item[i])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (!out_hold)
            rsp_valid_reg <= stage_valid[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold && stage_valid[LAST])
            rsp_item_reg <= stage_item[LAST];
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.user_result     = rsp_item_reg.user_result;
    assign rsp.suspend_running = rsp_item_reg.suspend_running;
    assign rsp.ready_mask      = rsp_item_reg.ready_mask;

    // checks
    `TGW_ASSERT_NOW(a_single_item, 1'b1, $onehot0(stage_valid))
    `TGW_ASSERT_NEXT(a_enter_head, entry_valid, stage_valid[0])
    `TGW_ASSERT_NEXT(a_tail_holds, stage_valid[LAST] && out_hold, stage_valid[LAST])
    `TGW_ASSERT_NOW(a_suspend_result, rsp.valid && rsp.suspend_running, rsp.user_result)
    `TGW_ASSERT_NOW(a_no_entry_with_result, rsp.valid, !req.ready)

endmodule

/* tb/tb_task_guard_wait_unit.sv */
// Self-checking testbench for task_guard_wait_unit: directed and random service items,
// with every result checked against a cycle-free model of the guard-wait state.
// Depends on tgw_pkg, tgw_req_if, tgw_rsp_if and the unit itself.
module tb_task_guard_wait_unit;
    import tgw_pkg::*;

    localparam int NUM_TASKS     = 32;
    localparam int NUM_GUARDS    = 16;
    localparam int TARGET_ITEMS  = 2000;
    localparam int IDLE_PCT      = 37;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int CALM_FROM     = 900;
    localparam int CALM_TO       = 1200;
    localparam int REPORT_MAX    = 10;

    // Op codes the unit has no use for
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]             op;
        logic [TASK_IDX_W-1:0]  runner;
        logic [GUARD_IDX_W-1:0] guard;
        logic                   accepted;
        logic [TIME_W-1:0]      time_value;
    } service_t;

    typedef struct packed {
        logic              user_result;
        logic              suspend_running;
        logic [MASK_W-1:0] ready_mask;
    } wake_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tgw_req_if req_ch ();
    tgw_rsp_if rsp_ch ();

    task_guard_wait_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive registers, known from time zero
    service_t cur_service = '0;
    logic     offer       = 1'b0;
    logic     take        = 1'b0;
    logic     hold        = 1'b0;

    assign req_ch.valid        = offer;
    assign req_ch.op           = cur_service.op;
    assign req_ch.running_task = cur_service.runner;
    assign req_ch.guard_index  = cur_service.guard;
    assign req_ch.accepted     = cur_service.accepted;
    assign req_ch.time_value   = cur_service.time_value;
    assign rsp_ch.ready        = take;

    service_t pending_services[$];
    wake_t    expected_wakes[$];

    int taken       = 0;
    int checked     = 0;
    int mismatches  = 0;
    int suspends    = 0;
    int woken       = 0;
    int stall_count = 0;
    int queued      = 0;
    logic calm;

    assign calm = (taken >= CALM_FROM) && (taken < CALM_TO);

    // Model state, one entry per task
    guard_state_t          task_gstate [NUM_TASKS];
    logic [NUM_GUARDS-1:0] task_guards [NUM_TASKS];
    logic                  task_armed  [NUM_TASKS];
    logic [TIME_W-1:0]     task_due    [NUM_TASKS];

    // Guard fired or deadline passed: drop guards, wake a waiter, flag an evaluator
    function automatic logic [MASK_W-1:0] fire_task(int t);
        task_guards[t] = '0;
        task_armed[t]  = 1'b0;
        if (task_gstate[t] == GST_WAITING)
        begin
            task_gstate[t] = GST_EVALUATING;
            return MASK_W'(1) << t;
        end
        if (task_gstate[t] == GST_EVALUATING)
            task_gstate[t] = GST_CHANGED;
        return '0;
    endfunction

    // Apply one service item to the model and return the result it should give
    function automatic wake_t apply_service(service_t s);
        wake_t r;
        int    rt;
        r  = '0;
        rt = int'(s.runner);
        case (s.op)
            OP_JOIN_GUARD:
                if (task_gstate[rt] == GST_EVALUATING)
                    task_guards[rt][s.guard] = 1'b1;
            OP_NOTE_ACCEPTED:
                if (s.accepted)
                begin
                    task_gstate[rt] = GST_EVALUATING;
                    task_guards[rt] = '0;
                    task_armed[rt]  = 1'b0;
                end
            OP_WAIT_CHANGE:
                if (task_gstate[rt] == GST_CHANGED)
                begin
                    r.user_result   = 1'b1;
                    task_gstate[rt] = GST_EVALUATING;
                end
                else if (task_armed[rt] || task_guards[rt] != '0)
                begin
                    r.user_result     = 1'b1;
                    r.suspend_running = 1'b1;
                    task_gstate[rt]   = GST_WAITING;
                end
            OP_GUARD_CHANGED:
                for (int t = 0; t < NUM_TASKS; t++)
                    if (task_guards[t][s.guard])
                        r.ready_mask |= fire_task(t);
            OP_ARM_DEADLINE:
                if (task_gstate[rt] == GST_EVALUATING)
                begin
                    // keep the earliest deadline
                    if (!task_armed[rt] || task_due[rt] > s.time_value)
                        task_due[rt] = s.time_value;
                    task_armed[rt] = 1'b1;
                end
            OP_TICK:
                for (int t = 0; t < NUM_TASKS; t++)
                    if (task_armed[t] && s.time_value >= task_due[t])
                        r.ready_mask |= fire_task(t);
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_service(logic [2:0] op, int runner, int guard,
                                        logic acc, logic [TIME_W-1:0] tv);
        service_t s;
        s.op         = op;
        s.runner     = TASK_IDX_W'(runner);
        s.guard      = GUARD_IDX_W'(guard);
        s.accepted   = acc;
        s.time_value = tv;
        pending_services.push_back(s);
        if (op < OP_SPARE_A)
            queued++;
    endfunction

    // Sender: offer the next queued item, with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            offer <= 1'b0;
        else
        begin
            if (offer && req_ch.ready)
            begin
                expected_wakes.push_back(apply_service(cur_service));
                taken <= taken + 1;
            end
            if (!offer || req_ch.ready)
            begin
                if (pending_services.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_service <= pending_services.pop_front();
                    offer       <= 1'b1;
                end
                else
                    offer <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest expectation
    always @(posedge clk)
    begin
        wake_t exp_w;
        if (!rst_n)
            take <= 1'b0;
        else
        begin
            if (rsp_ch.valid && take)
            begin
                checked <= checked + 1;
                if (expected_wakes.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: result with nothing expected: res=%0b susp=%0b mask=%h",
                                 $realtime, rsp_ch.user_result, rsp_ch.suspend_running,
                                 rsp_ch.ready_mask);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_w = expected_wakes.pop_front();
                    if (rsp_ch.user_result !== exp_w.user_result ||
                        rsp_ch.suspend_running !== exp_w.suspend_running ||
                        rsp_ch.ready_mask !== exp_w.ready_mask)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: mismatch exp res=%0b susp=%0b mask=%h, got res=%0b susp=%0b mask=%h",
                                     $realtime, exp_w.user_result, exp_w.suspend_running,
                                     exp_w.ready_mask, rsp_ch.user_result,
                                     rsp_ch.suspend_running, rsp_ch.ready_mask);
                        mismatches <= mismatches + 1;
                    end
                    suspends <= suspends + int'(exp_w.suspend_running);
                    woken    <= woken + $countones(exp_w.ready_mask);
                end
            end
            take <= !hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long back-pressure spell: the unit holds its item and stops taking new ones
    initial
    begin
        wait (taken >= HOLD_AT_ITEM);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((offer && req_ch.ready) || (rsp_ch.valid && take))
                stall_count <= 0;
            else if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                stall_count <= stall_count + 1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [TIME_W-1:0] now;
        int                t;
        int                n;

        for (int i = 0; i < NUM_TASKS; i++)
        begin
            task_gstate[i] = GST_EVALUATING;
            task_guards[i] = '0;
            task_armed[i]  = 1'b0;
            task_due[i]    = '0;
        end

        // Directed: edge tasks and guards, wake by guard and by deadline
        add_service(OP_JOIN_GUARD, 0, 0, 1'b0, '0);
        add_service(OP_JOIN_GUARD, 0, 15, 1'b1, '1);
        add_service(OP_JOIN_GUARD, 31, 15, 1'b0, '0);
        add_service(OP_ARM_DEADLINE, 31, 0, 1'b0, '1);
        add_service(OP_WAIT_CHANGE, 0, 0, 1'b0, '0);
        add_service(OP_WAIT_CHANGE, 31, 0, 1'b0, '0);
        add_service(OP_WAIT_CHANGE, 5, 0, 1'b0, '0);       // nothing joined: no suspend
        add_service(OP_GUARD_CHANGED, 0, 15, 1'b0, '0);    // wakes tasks 0 and 31
        add_service(OP_GUARD_CHANGED, 0, 0, 1'b0, '0);     // no members left
        // guard fires while the task is still evaluating
        add_service(OP_JOIN_GUARD, 3, 7, 1'b0, '0);
        add_service(OP_GUARD_CHANGED, 9, 7, 1'b0, '0);
        add_service(OP_JOIN_GUARD, 3, 2, 1'b0, '0);        // ignored, not evaluating
        add_service(OP_ARM_DEADLINE, 3, 0, 1'b0, 32'd10);  // ignored too
        add_service(OP_WAIT_CHANGE, 3, 0, 1'b0, '0);       // returns at once
        // accepted branch drops the guards
        add_service(OP_JOIN_GUARD, 4, 1, 1'b0, '0);
        add_service(OP_NOTE_ACCEPTED, 4, 0, 1'b0, '0);
        add_service(OP_NOTE_ACCEPTED, 4, 0, 1'b1, '0);
        add_service(OP_WAIT_CHANGE, 4, 0, 1'b0, '0);
        // earliest deadline kept, tick just short of it then on it
        add_service(OP_ARM_DEADLINE, 6, 0, 1'b0, 32'd100);
        add_service(OP_ARM_DEADLINE, 6, 0, 1'b0, 32'd200);
        add_service(OP_ARM_DEADLINE, 6, 0, 1'b0, 32'd50);
        add_service(OP_WAIT_CHANGE, 6, 0, 1'b0, '0);
        add_service(OP_TICK, 0, 0, 1'b0, 32'd49);
        add_service(OP_TICK, 0, 0, 1'b0, 32'd50);
        // deadline expiring on an evaluating task, then spare op codes
        add_service(OP_ARM_DEADLINE, 7, 0, 1'b0, '0);
        add_service(OP_TICK, 0, 0, 1'b0, '0);
        add_service(OP_SPARE_A, 31, 15, 1'b1, '1);
        add_service(OP_SPARE_B, 0, 0, 1'b0, '0);

        // Random: mostly join/arm/wait sequences, then signals and ticks
        now = 32'd1000;
        while (queued < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                t = $urandom_range(0, NUM_TASKS - 1);
                n = $urandom_range(0, 3);
                for (int k = 0; k < n; k++)
                    add_service(OP_JOIN_GUARD, t, $urandom_range(0, NUM_GUARDS - 1),
                                1'(  $urandom), $urandom);
                if ($urandom_range(0, 2) == 0)
                    add_service(OP_ARM_DEADLINE, t, $urandom_range(0, NUM_GUARDS - 1),
                                1'($urandom), now + $urandom_range(0, 60));
                if ($urandom_range(0, 5) == 0)
                    add_service(OP_NOTE_ACCEPTED, t, $urandom_range(0, NUM_GUARDS - 1),
                                1'($urandom), $urandom);
                if ($urandom_range(0, 99) < 85)
                    add_service(OP_WAIT_CHANGE, t, $urandom_range(0, NUM_GUARDS - 1),
                                1'($urandom), $urandom);
                if ($urandom_range(0, 99) < 45)
                    add_service(OP_GUARD_CHANGED, $urandom_range(0, NUM_TASKS - 1),
                                $urandom_range(0, NUM_GUARDS - 1), 1'($urandom), $urandom);
                if ($urandom_range(0, 99) < 40)
                begin
                    now = now + $urandom_range(0, 40);
                    add_service(OP_TICK, $urandom_range(0, NUM_TASKS - 1),
                                $urandom_range(0, NUM_GUARDS - 1), 1'($urandom), now);
                end
                // occasional jump of uptime, wrap included
                if ($urandom_range(0, 99) < 3)
                    now = $urandom;
            end
            else
                add_service(3'($urandom_range(0, 7)), $urandom_range(0, NUM_TASKS - 1),
                            $urandom_range(0, NUM_GUARDS - 1), 1'($urandom), $urandom);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain, then allow for one more pass through the cell row
        while (pending_services.size() != 0 || offer || expected_wakes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d service items through the unit and checked %0d results:",
                 taken, checked);
        $display("  %0d waits suspended, %0d task wake-ups, %0d mismatches",
                 suspends, woken, mismatches + expected_wakes.size());
        if (mismatches == 0 && expected_wakes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
